[hdl/plid_pkg.sv]
package plid_pkg;

	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_POS   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	localparam int POS_W   = 8;
	localparam int VAL_W   = 32;
	localparam int COUNT_W = 5;

	typedef struct packed {
		op_t                       opcode;
		logic [POS_W-1:0]          position;
		logic signed [VAL_W-1:0]   value;
	} cmd_t;

	typedef struct packed {
		status_t                   status;
		logic [COUNT_W-1:0]        entry_count;
	} rsp_t;

	typedef struct packed {
		logic                      ins;
		logic                      del;
		logic [POS_W-1:0]          idx;
	} shift_ctl_t;

endpackage

[hdl/positional_list_insert_delete_core.sv]
// Ordered list of up to CAPACITY signed 32-bit values, one storage cell per entry.
// A command is presented on cmd with start high; it is taken at the clock edge
// where start is high and busy is low. Busy never rises, so one command can be
// taken in every cycle.
// Each command produces exactly one result on rsp, marked by done for one cycle,
// in the cycle after the command is taken, and throughput is one command per
// cycle. The result carries the status (done, rejected for an empty list, a bad
// position or an unknown opcode, or list full) and the entry count afterwards.
// On each accepted insert or delete, every cell compares its own index with the
// target index and loads from its left neighbor, its right neighbor or the
// inserted value, or holds, so the whole shift completes at the accepting edge.
// Reset clears the entry count and the result strobe; the cells keep whatever
// they held, since only occupied entries are ever moved into the live range.
// The receiver cannot stall; a result must be captured in the cycle done is high.
module positional_list_insert_delete_core #(
	parameter int CAPACITY = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  plid_pkg::cmd_t  cmd,
	output logic            done,
	output plid_pkg::rsp_t  rsp
);
	import plid_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]         occ_q;
	logic [CNT_W-1:0]         occ_nxt;
	logic                     done_q;
	status_t                  status_q;
	logic [COUNT_W-1:0]       count_q;
	status_t                  status_nxt;
	shift_ctl_t               ctl;
	logic                     accept;
	logic                     full;
	logic [8:0]               occ9;
	logic [8:0]               pos9;
	logic [8:0]               occ_m1;
	logic [CNT_W+COUNT_W-1:0] occ_wide;
	logic signed [VAL_W-1:0]  entries [CAPACITY];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign occ9   = 9'(occ_q);
	assign pos9   = {1'b0, cmd.position};
	assign occ_m1 = occ9 - 9'd1;
	assign full   = occ9 >= 9'(CAPACITY);

	always_comb begin
		ctl        = '0;
		status_nxt = ST_REJECT;
		occ_nxt    = occ_q;
		case (cmd.opcode)
			OP_INS_FRONT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					status_nxt = ST_OK;
					ctl.ins    = 1'b1;
					ctl.idx    = '0;
				end
			end
			OP_INS_BACK: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					status_nxt = ST_OK;
					ctl.ins    = 1'b1;
					ctl.idx    = occ9[POS_W-1:0];
				end
			end
			OP_INS_POS: begin
				if (pos9 == 9'd0 || pos9 > occ9 + 9'd1) begin
					status_nxt = ST_REJECT;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					status_nxt = ST_OK;
					ctl.ins    = 1'b1;
					ctl.idx    = cmd.position - 8'd1;
				end
			end
			OP_DEL_FRONT: begin
				if (occ9 != 9'd0) begin
					status_nxt = ST_OK;
					ctl.del    = 1'b1;
					ctl.idx    = '0;
				end
			end
			OP_DEL_BACK: begin
				if (occ9 != 9'd0) begin
					status_nxt = ST_OK;
					ctl.del    = 1'b1;
					ctl.idx    = occ_m1[POS_W-1:0];
				end
			end
			OP_DEL_POS: begin
				if (pos9 != 9'd0 && pos9 <= occ9) begin
					status_nxt = ST_OK;
					ctl.del    = 1'b1;
					ctl.idx    = cmd.position - 8'd1;
				end
			end
			default: begin
				status_nxt = ST_REJECT;
			end
		endcase
		if (!accept) begin
			ctl.ins = 1'b0;
			ctl.del = 1'b0;
		end
		if (ctl.ins) begin
			occ_nxt = occ_q + CNT_W'(1);
		end else if (ctl.del) begin
			occ_nxt = occ_q - CNT_W'(1);
		end
	end

	assign occ_wide = {{COUNT_W{1'b0}}, occ_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			done_q <= 1'b0;
		end else begin
			occ_q  <= occ_nxt;
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			count_q  <= occ_wide[COUNT_W-1:0];
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_v;
		logic signed [VAL_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = entries[i];
		end else begin : g_mid_l
			assign left_v = entries[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = entries[i];
		end else begin : g_mid_r
			assign right_v = entries[i+1];
		end
		plid_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.ins_value(cmd.value),
			.left     (left_v),
			.right    (right_v),
			.entry    (entries[i])
		);
	end

	assign done            = done_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = count_q;

endmodule

[hdl/plid_cell.sv]
module plid_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                           clk,
	input  plid_pkg::shift_ctl_t           ctl,
	input  logic signed [plid_pkg::VAL_W-1:0] ins_value,
	input  logic signed [plid_pkg::VAL_W-1:0] left,
	input  logic signed [plid_pkg::VAL_W-1:0] right,
	output logic signed [plid_pkg::VAL_W-1:0] entry
);
	import plid_pkg::*;

	localparam logic [POS_W-1:0] MY_IDX = CELL_IDX[POS_W-1:0];

	logic signed [VAL_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_IDX > ctl.idx) begin
				entry_q <= left;
			end else if (MY_IDX == ctl.idx) begin
				entry_q <= ins_value;
			end
		end else if (ctl.del) begin
			if (MY_IDX >= ctl.idx) begin
				entry_q <= right;
			end
		end
	end

	assign entry = entry_q;

endmodule
